// ===== src/b64c_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and character-mapping functions for the base64url codec.
// No dependencies; used by every other file of the block.
package b64c_pkg;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Direction register values
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   // ASCII anchors of the URL-safe alphabet
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5a;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7a;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_MINUS   = 8'h2d;
   localparam logic [7:0] CH_UNDER   = 8'h5f;

   // One result beat
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       last;
      logic       err;
   } res_type;

   // Results caused by one input item (one or two)
   typedef struct packed {
      logic    two;
      res_type second;
      res_type first;
   } job_type;

   // 6-bit value to alphabet character
   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] w;
      logic [7:0] c;
      w = {2'b00, v};
      if (v < 6'd26) begin
         c = CH_UPPER_A + w;
      end else if (v < 6'd52) begin
         c = CH_LOWER_A + w - 8'd26;
      end else if (v < 6'd62) begin
         c = CH_DIGIT_0 + w - 8'd52;
      end else if (v == 6'd62) begin
         c = CH_MINUS;
      end else begin
         c = CH_UNDER;
      end
      return c;
   endfunction

   // Character to {valid, 6-bit value}; valid low for anything outside the alphabet
   function automatic logic [6:0] dec_char(input logic [7:0] c);
      logic [7:0] t;
      logic       ok;
      t  = 8'd0;
      ok = 1'b1;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         t = c - CH_UPPER_A;
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         t = c - CH_LOWER_A + 8'd26;
      end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
         t = c - CH_DIGIT_0 + 8'd52;
      end else if (c == CH_MINUS) begin
         t = 8'd62;
      end else if (c == CH_UNDER) begin
         t = 8'd63;
      end else begin
         ok = 1'b0;
      end
      return {ok, t[5:0]};
   endfunction

endpackage

// ===== src/b64c_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input beats, tracks the group phase and carried bits,
// and forms up to two result beats per item. Depends on b64c_pkg.
module b64c_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              direction,
   input  logic              clear,
   input  logic              req_push,
   input  logic [7:0]        req_in_byte,
   input  logic              req_in_last,
   output logic              req_full,
   input  logic              q_full,
   output logic              q_push,
   output b64c_pkg::job_type q_job
);

   logic [1:0] phase_ff, phase_in;
   logic [5:0] carry_ff, carry_in;
   logic       failed_ff, failed_in;

   logic                accept;
   logic                have;
   logic [6:0]          dec;
   logic [5:0]          flush;
   logic                has_flush;
   b64c_pkg::res_type   r0, r1;
   logic                two;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign dec      = b64c_pkg::dec_char(req_in_byte);

   // Classify the item and work out results and next message state
   always_comb begin
      phase_in  = phase_ff;
      carry_in  = carry_ff;
      failed_in = failed_ff;
      r0        = '0;
      r1        = '0;
      two       = 1'b0;
      have      = 1'b0;
      flush     = '0;
      has_flush = 1'b0;

      if (failed_ff) begin
         // message already aborted: swallow beats until the last one
         if (req_in_last) begin
            phase_in  = '0;
            carry_in  = '0;
            failed_in = 1'b0;
         end
      end else if (direction == b64c_pkg::DIR_ENCODE) begin
         have     = 1'b1;
         r0.valid = 1'b1;
         case (phase_ff)
            2'd1: begin
               r0.data   = b64c_pkg::enc_char({carry_ff[1:0], req_in_byte[7:4]});
               carry_in  = {2'b00, req_in_byte[3:0]};
               phase_in  = 2'd2;
               flush     = {req_in_byte[3:0], 2'b00};
               has_flush = 1'b1;
            end
            2'd2: begin
               r0.data  = b64c_pkg::enc_char({carry_ff[3:0], req_in_byte[7:6]});
               r1.data  = b64c_pkg::enc_char(req_in_byte[5:0]);
               r1.valid = 1'b1;
               two      = 1'b1;
               carry_in = '0;
               phase_in = 2'd0;
            end
            default: begin
               r0.data   = b64c_pkg::enc_char(req_in_byte[7:2]);
               carry_in  = {4'b0000, req_in_byte[1:0]};
               phase_in  = 2'd1;
               flush     = {req_in_byte[1:0], 4'b0000};
               has_flush = 1'b1;
            end
         endcase
         if (req_in_last) begin
            // partial group goes out as a final character
            if (has_flush) begin
               r1.data  = b64c_pkg::enc_char(flush);
               r1.valid = 1'b1;
               two      = 1'b1;
            end
            r1.last  = 1'b1;
            phase_in = '0;
            carry_in = '0;
         end
      end else if (!dec[6]) begin
         // character outside the alphabet aborts the message
         have      = 1'b1;
         r0.last   = 1'b1;
         r0.err    = 1'b1;
         phase_in  = '0;
         carry_in  = '0;
         failed_in = !req_in_last;
      end else begin
         r0.valid = 1'b1;
         r0.last  = req_in_last;
         case (phase_ff)
            2'd0: begin
               carry_in = dec[5:0];
               phase_in = 2'd1;
            end
            2'd1: begin
               have     = 1'b1;
               r0.data  = {carry_ff[5:0], dec[5:4]};
               carry_in = {2'b00, dec[3:0]};
               phase_in = 2'd2;
            end
            2'd2: begin
               have     = 1'b1;
               r0.data  = {carry_ff[3:0], dec[5:2]};
               carry_in = {4'b0000, dec[1:0]};
               phase_in = 2'd3;
            end
            default: begin
               have     = 1'b1;
               r0.data  = {carry_ff[1:0], dec[5:0]};
               carry_in = '0;
               phase_in = 2'd0;
            end
         endcase
         if (req_in_last) begin
            // nothing complete: bare end marker
            if (!have) begin
               have     = 1'b1;
               r0.valid = 1'b0;
            end
            phase_in = '0;
            carry_in = '0;
         end
      end
   end

   assign q_push       = accept && have;
   assign q_job.first  = r0;
   assign q_job.second = r1;
   assign q_job.two    = two;

   // Message state
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         phase_ff  <= '0;
         carry_ff  <= '0;
         failed_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         carry_ff  <= carry_in;
         failed_ff <= failed_in;
      end
   end

endmodule

// ===== src/b64c_queue.sv =====
`timescale 1ns / 1ps
// Short job queue between the front and back ends.
// Depends on b64c_pkg for the job type.
module b64c_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64c_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output b64c_pkg::job_type head_job,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64c_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign head_job = slot_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ===== src/b64c_back.sv =====
`timescale 1ns / 1ps
// Back end: walks the results of the queued job and presents them one beat
// at a time from an output register. Depends on b64c_pkg.
module b64c_back (
   input  logic              clock,
   input  logic              reset,
   input  b64c_pkg::job_type head_job,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_out_valid,
   output logic              rsp_out_last,
   output logic              rsp_error
);

   b64c_pkg::res_type out_ff, out_in;
   logic              full_ff, full_in;
   logic              sel_ff, sel_in;
   logic              load, take, done;

   // Load a new beat when the output register is free or being drained
   assign load  = !full_ff || rsp_pop;
   assign take  = load && !q_empty;
   assign done  = !head_job.two || sel_ff;
   assign q_pop = take && done;

   always_comb begin
      out_in  = sel_ff ? head_job.second : head_job.first;
      full_in = take || (full_ff && !rsp_pop);
      sel_in  = take ? !done : sel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         sel_ff  <= 1'b0;
      end else begin
         full_ff <= full_in;
         sel_ff  <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= out_in;
      end
   end

   assign rsp_empty     = !full_ff;
   assign rsp_out_byte  = out_ff.data;
   assign rsp_out_valid = out_ff.valid;
   assign rsp_out_last  = out_ff.last;
   assign rsp_error     = out_ff.err;

endmodule

// ===== src/base64url_codec_unit.sv =====
`timescale 1ns / 1ps
// Streaming base64url codec (no padding); direction chosen by a register.
// The first result beat passes through the job queue and then the output register.
// Throughput: one input beat per cycle for items with one result while the job
// queue has room; items with two are paced by the single-beat output register.
// Reset clears direction (encode), message state, the job queue and output.
// Depends on b64c_pkg, b64c_front, b64c_queue and b64c_back.
module base64url_codec_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [7:0]                      req_in_byte,
   input  logic                            req_in_last,
   // result channel
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_out_valid,
   output logic                            rsp_out_last,
   output logic                            rsp_error,
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [b64c_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [b64c_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [b64c_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic              dir_ff, dir_in;
   logic              dir_sel;
   logic              dir_wr;
   logic              q_push, q_pop, q_full, q_empty;
   b64c_pkg::job_type q_in_job, q_head_job;

   // Direction register, any address with the top bit clear; writing it starts a fresh message
   assign csr_pready = 1'b1;
   assign dir_sel    = (csr_paddr[b64c_pkg::CSR_ADDR_W-1] == 1'b0);
   assign dir_wr     = csr_psel && csr_penable && csr_pwrite && dir_sel;
   assign dir_in     = dir_wr ? csr_pwdata[0] : dir_ff;
   assign csr_prdata = dir_sel ? {{(b64c_pkg::CSR_DATA_W-1){1'b0}}, dir_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= b64c_pkg::DIR_ENCODE;
      end else begin
         dir_ff <= dir_in;
      end
   end

   b64c_front u_front (
      .clock       (clock),
      .reset       (reset),
      .direction   (dir_ff),
      .clear       (dir_wr),
      .req_push    (req_push),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .req_full    (req_full),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (q_in_job)
   );

   b64c_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_in_job),
      .full     (q_full),
      .pop      (q_pop),
      .head_job (q_head_job),
      .empty    (q_empty)
   );

   b64c_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_job      (q_head_job),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_last  (rsp_out_last),
      .rsp_error     (rsp_error)
   );

endmodule
